[design/atr_pkg.sv]
// ----------------------------------------------------------------------------
// ATR filter package
// Shared widths, register indexes, queue entry and back-end state types.
// ----------------------------------------------------------------------------
package atr_pkg;

  localparam int PRICE_W  = 32;
  localparam int PERIOD_W = 9;
  localparam int SUM_W    = PRICE_W + PERIOD_W;
  localparam int SCALE_W  = 7;
  localparam int NUM_W    = SUM_W + SCALE_W;
  localparam int DEN_W    = PRICE_W + PERIOD_W;
  localparam int FRAC_W   = 16;
  localparam int QUOT_W   = 32;
  localparam int IN_DATA_W  = 3 * PRICE_W;
  localparam int OUT_DATA_W = 72;

  localparam logic [SCALE_W-1:0]  PercentScale  = 7'd100;
  localparam logic [PERIOD_W-1:0] PeriodDefault = 9'd14;

  typedef enum logic {
    REG_ATR_PERIOD      = 1'b0,
    REG_MAX_ATR_PERCENT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [PRICE_W-1:0] true_range;
    logic [PRICE_W-1:0] close;
  } bar_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_PRODUCT,
    BK_DIV_START,
    BK_DIV_WAIT,
    BK_FINISH
  } back_state_t;

endpackage

[design/atr_front.sv]
// ----------------------------------------------------------------------------
// ATR front end
// Accepts price bars, forms the true range and queues it with the close.
// ----------------------------------------------------------------------------
module atr_front #(
  parameter int PRICE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [atr_pkg::IN_DATA_W-1:0] s_tdata,  // bar_high, bar_low, bar_close
  output logic                         push_valid,
  input  logic                         push_ready,
  output atr_pkg::bar_entry_t          push_data
);
  import atr_pkg::*;

  localparam logic [PRICE_W-1:0] PriceMask =
    (PRICE_BITS >= PRICE_W) ? {PRICE_W{1'b1}} : PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);

  logic [PRICE_W-1:0] previous_close;
  logic               have_previous;
  logic [PRICE_W-1:0] high, low, close;
  logic [PRICE_W-1:0] spread, up_gap, down_gap, tr;
  logic               accept;

  always_comb begin
    high     = s_tdata[PRICE_W-1:0] & PriceMask;
    low      = s_tdata[2*PRICE_W-1:PRICE_W] & PriceMask;
    close    = s_tdata[3*PRICE_W-1:2*PRICE_W] & PriceMask;
    spread   = (high >= low) ? high - low : low - high;
    up_gap   = (high >= previous_close) ? high - previous_close : previous_close - high;
    down_gap = (low >= previous_close) ? low - previous_close : previous_close - low;
    tr       = spread;
    if (have_previous) begin
      if (up_gap > tr) tr = up_gap;
      if (down_gap > tr) tr = down_gap;
    end
  end

  assign s_tready             = push_ready;
  assign push_valid           = s_tvalid;
  assign push_data.true_range = tr;
  assign push_data.close      = close;
  assign accept               = s_tvalid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_close <= '0;
      have_previous  <= 1'b0;
    end else if (accept) begin
      previous_close <= close;
      have_previous  <= 1'b1;
    end
  end

endmodule

[design/atr_queue.sv]
// ----------------------------------------------------------------------------
// ATR bar queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module atr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  atr_pkg::bar_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output atr_pkg::bar_entry_t pop_data
);
  import atr_pkg::*;

  bar_entry_t entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/atr_div.sv]
// ----------------------------------------------------------------------------
// ATR Q16.16 divider
// Restoring divider, one quotient bit per cycle, saturating at all ones.
// ----------------------------------------------------------------------------
module atr_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [atr_pkg::NUM_W-1:0]  num,
  input  logic [atr_pkg::DEN_W-1:0]  den,
  output logic                      done,
  output logic [atr_pkg::QUOT_W-1:0] quot
);
  import atr_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic [DEN_W-1:0]  rem, den_r;
  logic [QUOT_W-1:0] xs;
  logic [CNT_W-1:0]  cnt;
  logic              run;
  logic [DEN_W:0]    trial, diff;
  logic              take;
  logic              sat;

  assign sat   = {{(DEN_W + FRAC_W - NUM_W){1'b0}}, num} >= {den, {FRAC_W{1'b0}}};
  assign trial = {rem, xs[QUOT_W-1]};
  assign take  = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (sat) begin
          done <= 1'b1;
        end else begin
          run <= 1'b1;
          cnt <= CNT_W'(QUOT_W);
        end
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= DEN_W'(num[NUM_W-1:FRAC_W]);
      xs    <= {num[FRAC_W-1:0], {(QUOT_W - FRAC_W){1'b0}}};
      quot  <= sat ? {QUOT_W{1'b1}} : '0;
    end else if (run) begin
      rem  <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      xs   <= {xs[QUOT_W-2:0], 1'b0};
      quot <= {quot[QUOT_W-2:0], take};
    end
  end

endmodule

[design/atr_back.sv]
// ----------------------------------------------------------------------------
// ATR back end
// Window ring with running sum, scaling products, division and result register.
// ----------------------------------------------------------------------------
module atr_back #(
  parameter int MAX_PERIOD = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  atr_pkg::bar_entry_t            pop_data,
  input  logic [atr_pkg::PERIOD_W-1:0]   atr_period,
  input  logic [atr_pkg::PRICE_W-1:0]    max_atr_percent,
  input  logic                           restart,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [atr_pkg::OUT_DATA_W-1:0] m_tdata
);
  import atr_pkg::*;

  localparam int AW    = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
  localparam int SLW   = (AW > PERIOD_W) ? AW : PERIOD_W;
  localparam int NCap  = (MAX_PERIOD > 511) ? 511 : MAX_PERIOD;

  back_state_t state, state_next;
  logic [PRICE_W-1:0]  range_history [MAX_PERIOD];
  logic [PRICE_W-1:0]  old_range;
  logic [SUM_W-1:0]    range_sum, sum_base, range_sum_next;
  logic [PERIOD_W-1:0] bars_seen, bars_next, n;
  logic [AW-1:0]       write_slot, slot_next;
  logic [SLW-1:0]      slot_inc;
  logic [PRICE_W-1:0]  tr_r, close_r;
  logic                full_r, do_div_r, do_div;
  logic [NUM_W-1:0]    num_r;
  logic [DEN_W-1:0]    den_r;
  logic                upd, prod, div_start, load, div_done;
  logic [QUOT_W-1:0]   div_quot, pct;
  logic                allowed;

  assign n = (atr_period > PERIOD_W'(NCap)) ? PERIOD_W'(NCap) : atr_period;

  always_comb begin
    sum_base       = (bars_seen >= n) ? range_sum - SUM_W'(old_range) : range_sum;
    range_sum_next = sum_base + SUM_W'(tr_r);
    bars_next      = (bars_seen < n) ? bars_seen + 1'b1 : bars_seen;
    slot_inc       = SLW'(write_slot) + 1'b1;
    slot_next      = (slot_inc == SLW'(n)) ? '0 : slot_inc[AW-1:0];
    do_div         = full_r && (close_r != '0);
    pct            = do_div_r ? div_quot : '0;
    allowed        = (max_atr_percent == '0) || (pct <= max_atr_percent);
  end

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:      if (pop_valid) state_next = BK_UPDATE;
      BK_UPDATE:    state_next = BK_PRODUCT;
      BK_PRODUCT:   state_next = do_div ? BK_DIV_START : BK_FINISH;
      BK_DIV_START: state_next = BK_DIV_WAIT;
      BK_DIV_WAIT:  if (div_done) state_next = BK_FINISH;
      BK_FINISH:    if (!m_tvalid || m_tready) state_next = BK_IDLE;
      default:      state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready = (state == BK_IDLE);
    upd       = (state == BK_UPDATE);
    prod      = (state == BK_PRODUCT);
    div_start = (state == BK_DIV_START);
    load      = (state == BK_FINISH) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_IDLE;
      range_sum  <= '0;
      bars_seen  <= '0;
      write_slot <= '0;
      full_r     <= 1'b0;
      do_div_r   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (restart) begin
        range_sum  <= '0;
        bars_seen  <= '0;
        write_slot <= '0;
      end else if (upd && n != '0) begin
        range_sum  <= range_sum_next;
        bars_seen  <= bars_next;
        write_slot <= slot_next;
      end
      if (upd) full_r <= (n != '0) && (bars_next >= n);
      if (prod) do_div_r <= do_div;
      if (load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      tr_r      <= pop_data.true_range;
      close_r   <= pop_data.close;
      old_range <= range_history[write_slot];
    end
    if (upd && n != '0) range_history[write_slot] <= tr_r;
    if (prod) begin
      num_r <= range_sum * PercentScale;
      den_r <= n * close_r;
    end
    if (load) m_tdata <= {{(OUT_DATA_W - 2 - QUOT_W - PRICE_W){1'b0}}, allowed, full_r, pct, tr_r};
  end

  atr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule

[design/average_true_range_filter.sv]
// ----------------------------------------------------------------------------
// Average true range filter
// Reports ATR as a Q16.16 percentage of close with a volatility ceiling flag.
// ----------------------------------------------------------------------------
// Each bar that needs a division passes through window update and scaling,
// then a 32-step restoring divider that yields one quotient bit per cycle.
// A bar with a partial window, a zero period or a zero close skips the
// divider. A two-entry queue lets the front end keep taking bars while one
// is divided, and a result register holds the finished transaction until it
// is taken. No clearing pass runs after reset.
module average_true_range_filter #(
  parameter int MAX_PERIOD = 256,
  parameter int PRICE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [atr_pkg::IN_DATA_W-1:0]   s_tdata,  // bar_high, bar_low, bar_close
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // true_range, atr_percent, window_full, volatility_allowed, zero fill
  output logic [atr_pkg::OUT_DATA_W-1:0]  m_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [atr_pkg::PRICE_W-1:0]     cfg_data
);
  import atr_pkg::*;

  logic [PERIOD_W-1:0] atr_period;
  logic [PRICE_W-1:0]  max_atr_percent;
  logic                restart;
  logic                push_valid, push_ready, pop_valid, pop_ready;
  bar_entry_t          push_data, pop_data;

  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == REG_ATR_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      atr_period      <= PeriodDefault;
      max_atr_percent <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ATR_PERIOD:      atr_period <= cfg_data[PERIOD_W-1:0];
        REG_MAX_ATR_PERCENT: max_atr_percent <= cfg_data;
        default:             atr_period <= atr_period;
      endcase
    end
  end

  atr_front #(.PRICE_BITS(PRICE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  atr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  atr_back #(.MAX_PERIOD(MAX_PERIOD)) u_back (
    .clk             (clk),
    .rst             (rst),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .atr_period      (atr_period),
    .max_atr_percent (max_atr_percent),
    .restart         (restart),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

`ifndef SYNTH
  a_partial_window_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[64]) |-> (m_tdata[63:32] == '0))
    else $error("percent nonzero while window not full");

  a_ready_after_reset: assert property (@(posedge clk)
    ($past(rst) && !rst) |-> s_tready)
    else $error("input not ready after reset");

  a_queue_from_back: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> !pop_ready)
    else $error("back end took two bars back to back");
`endif

endmodule
